### rtl/twebs_pkg.sv
`timescale 1ns / 1ps

package twebs_pkg;

  // trace and window geometry
  localparam int WINDOW_MAX   = 128;
  localparam int SAMPLE_BITS  = 12;
  localparam int TRACE_MAX    = 2048;
  localparam int WINDOW_RESET = 100;
  localparam int SEEN_CAP     = (TRACE_MAX > WINDOW_MAX) ? TRACE_MAX : WINDOW_MAX;

  // port field widths
  localparam int CFG_W  = 8;
  localparam int IN_W   = 16;
  localparam int Q4_W   = 16;
  localparam int DIFF_W = Q4_W + 1;
  localparam int OUT_W  = 88;

  // derived internal widths
  localparam int RING_AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int N_W     = $clog2(WINDOW_MAX + 1);
  localparam int SEEN_W  = $clog2(SEEN_CAP + 1);
  localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW_MAX + 1);
  localparam int SQ_W    = 2 * SAMPLE_BITS + $clog2(WINDOW_MAX + 1);
  localparam int MA_W    = SQ_W;
  localparam int MB_W    = (SUM_W > N_W) ? SUM_W : N_W;
  localparam int MUL_W   = MA_W + MB_W;
  localparam int PROD_W  = (N_W + SQ_W > 2 * SUM_W) ? (N_W + SQ_W) : (2 * SUM_W);
  localparam int RAD_W   = 2 * ((PROD_W + 8 + 1) / 2);
  localparam int ROOT_W  = RAD_W / 2;
  localparam int DIV_W   = (ROOT_W > SUM_W + 4) ? ROOT_W : (SUM_W + 4);
  localparam int DCNT_W  = $clog2(DIV_W);
  localparam int SCNT_W  = $clog2(ROOT_W);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_OLDSQ,
    ST_UPD,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_MULA,
    ST_MULB,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_RMS_WAIT,
    ST_OUT
  } state_t;

endpackage

### rtl/twebs_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module twebs_div import twebs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [N_W-1:0]    divisor,
  output logic              done,
  output logic [DIV_W-1:0]  quotient
);

  logic              run;
  logic [DCNT_W-1:0] cnt;
  logic [N_W-1:0]    rem;
  logic [N_W:0]      rem_sh;
  logic              take;

  assign rem_sh = {rem, quotient[DIV_W-1]};
  assign take   = (rem_sh >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == DCNT_W'(DIV_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (run) begin
      quotient <= {quotient[DIV_W-2:0], take};
      rem      <= take ? N_W'(rem_sh - {1'b0, divisor}) : N_W'(rem_sh);
    end
  end

endmodule

### rtl/twebs_sqrt.sv
`timescale 1ns / 1ps

// digit-by-digit integer square root, one root bit per cycle
module twebs_sqrt import twebs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic              run;
  logic [SCNT_W-1:0] cnt;
  logic [RAD_W-1:0]  rad;
  logic [ROOT_W:0]   rem;
  logic [ROOT_W+2:0] rem_sh;
  logic [ROOT_W+2:0] trial;
  logic              take;

  assign rem_sh = {rem, rad[RAD_W-1:RAD_W-2]};
  assign trial  = (ROOT_W + 3)'({root, 2'b01});
  assign take   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == SCNT_W'(ROOT_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (run) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= take ? (ROOT_W + 1)'(rem_sh - trial) : (ROOT_W + 1)'(rem_sh);
      root <= {root[ROOT_W-2:0], take};
    end
  end

endmodule

### rtl/trace_edge_window_baseline_stats.sv
`timescale 1ns / 1ps

// Baseline mean and RMS at both ends of an ADC trace. Samples stream in one per
// beat, the final one flagged by s_axis_tlast. The block keeps running sums of x
// and x*x over the first window_length samples, and over the last window_length
// samples through a 128-entry sample ring with add/subtract sums; the windows may
// overlap. On the last beat it emits one result beat: both means, both RMS values
// (sqrt(n*Sxx - Sx^2)/n) and lead mean minus trailing mean. The means and RMS
// values are unsigned fixed point with 4 fraction bits, the difference 17-bit
// two's complement with 4 fraction bits, all truncated. A trace shorter than
// the window gives zero results with m_axis_tuser set. window_length of 0 acts
// as 1, above 128 as 128; it is latched on the first sample of each trace. Each
// sample passes through accept, then three update steps through the one shared
// multiplier and the sum adders. After the last sample and before the result
// beat, each window goes through a serial divide for the mean, two multiplies,
// a serial square root and another serial divide for the RMS. The input is not
// ready meanwhile; a waiting result beat stalls only the end of the next trace.
module trace_edge_window_baseline_stats import twebs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  // configuration: window_length
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  // sample stream
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // [11:0] sample
  input  logic             s_axis_tlast,   // last_sample
  // result stream
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,   // [15:0] mean_first, [31:16] rms_first,
                                           // [47:32] mean_trailing, [63:48] rms_trailing,
                                           // [80:64] mean_difference
  output logic             m_axis_tuser    // short_trace
);

  state_t state, state_next;

  // config and per-trace window size
  logic [CFG_W-1:0]       window_length;
  logic [N_W-1:0]         n_cfg;
  logic [N_W-1:0]         n_cur;
  logic [N_W-1:0]         active_n;

  // running sums and trace position
  logic [SUM_W-1:0]       lead_sum, trail_sum;
  logic [SQ_W-1:0]        lead_sq, trail_sq;
  logic [SEEN_W-1:0]      seen;
  logic [RING_AW-1:0]     ring_pos;
  logic [RING_AW-1:0]     rd_idx;
  logic [N_W:0]           pos_ext;

  // sample ring
  logic [SAMPLE_BITS-1:0] ring [WINDOW_MAX];
  logic [SAMPLE_BITS-1:0] old_s;

  // per-sample flags
  logic [SAMPLE_BITS-1:0] s_reg;
  logic                   last_reg, lead_in, drop_old, short_flag;

  // shared multiplier
  logic [MA_W-1:0]        mul_a;
  logic [MB_W-1:0]        mul_b;
  logic [MUL_W-1:0]       mul_full;
  logic [PROD_W-1:0]      prod;
  logic [PROD_W-1:0]      a_reg;
  logic [PROD_W-1:0]      var_v;

  // result phase
  logic                   win_sel;
  logic [SUM_W-1:0]       sx_sel;
  logic [SQ_W-1:0]        sxx_sel;
  logic                   div_start, div_done, sqrt_start, sqrt_done;
  logic [DIV_W-1:0]       div_dividend, div_q;
  logic [ROOT_W-1:0]      sqrt_root;
  logic [Q4_W-1:0]        mean_f, rms_f, mean_t, rms_t;
  logic [DIFF_W-1:0]      mean_diff;

  logic                   s_acc, out_free;

  // no sample is taken while reset is held
  assign s_axis_tready = (state == ST_IDLE) && !rst;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // window size clamp: zero acts as one, oversize acts as the ring depth
  always_comb begin
    if (window_length == '0) begin
      n_cfg = N_W'(1);
    end else if ((N_W + CFG_W)'(window_length) > (N_W + CFG_W)'(WINDOW_MAX)) begin
      n_cfg = N_W'(WINDOW_MAX);
    end else begin
      n_cfg = N_W'(window_length);
    end
  end

  assign n_cur = (seen == '0) ? n_cfg : active_n;

  // ring slot that leaves the trailing window
  always_comb begin
    if ((N_W + 1)'(ring_pos) >= (N_W + 1)'(n_cur)) begin
      pos_ext = (N_W + 1)'(ring_pos) - (N_W + 1)'(n_cur);
    end else begin
      pos_ext = (N_W + 1)'(ring_pos) + (N_W + 1)'(WINDOW_MAX) - (N_W + 1)'(n_cur);
    end
  end
  assign rd_idx = RING_AW'(pos_ext);

  assign sx_sel  = win_sel ? trail_sum : lead_sum;
  assign sxx_sel = win_sel ? trail_sq  : lead_sq;
  assign var_v   = (a_reg > prod) ? (a_reg - prod) : '0;

  assign mul_full = MUL_W'(mul_a) * MUL_W'(mul_b);

  // sequencer: next state and unit controls
  always_comb begin
    state_next   = state;
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    div_dividend = '0;
    sqrt_start   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (s_acc) state_next = ST_SQ;
      end
      ST_SQ: begin
        mul_a      = MA_W'(s_reg);
        mul_b      = MB_W'(s_reg);
        state_next = ST_OLDSQ;
      end
      ST_OLDSQ: begin
        mul_a      = MA_W'(old_s);
        mul_b      = MB_W'(old_s);
        state_next = ST_UPD;
      end
      ST_UPD: begin
        if (!last_reg) begin
          state_next = ST_IDLE;
        end else if (seen < SEEN_W'(active_n)) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_MEAN_GO;
        end
      end
      ST_MEAN_GO: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'({sx_sel, 4'b0000});
        state_next   = ST_MEAN_WAIT;
      end
      ST_MEAN_WAIT: begin
        if (div_done) state_next = ST_MULA;
      end
      ST_MULA: begin
        mul_a      = MA_W'(sxx_sel);
        mul_b      = MB_W'(active_n);
        state_next = ST_MULB;
      end
      ST_MULB: begin
        mul_a      = MA_W'(sx_sel);
        mul_b      = MB_W'(sx_sel);
        state_next = ST_SQRT_GO;
      end
      ST_SQRT_GO: begin
        sqrt_start = 1'b1;
        state_next = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: begin
        if (sqrt_done) begin
          div_start    = 1'b1;
          div_dividend = DIV_W'(sqrt_root);
          state_next   = ST_RMS_WAIT;
        end
      end
      ST_RMS_WAIT: begin
        if (div_done) state_next = win_sel ? ST_OUT : ST_MEAN_GO;
      end
      ST_OUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= CFG_W'(WINDOW_RESET);
    end else if (cfg_we) begin
      window_length <= cfg_wdata;
    end
  end

  // ring write and registered read, both at accept
  always_ff @(posedge clk) begin
    if (s_acc) begin
      ring[ring_pos] <= s_axis_tdata[SAMPLE_BITS-1:0];
      old_s          <= ring[rd_idx];
    end
  end

  // multiplier output register
  always_ff @(posedge clk) begin
    prod <= mul_full[PROD_W-1:0];
  end

  // per-sample flags and latched sample
  always_ff @(posedge clk) begin
    if (s_acc) begin
      s_reg    <= s_axis_tdata[SAMPLE_BITS-1:0];
      last_reg <= s_axis_tlast;
      lead_in  <= (seen < SEEN_W'(n_cur));
      drop_old <= (seen >= SEEN_W'(n_cur));
    end
  end

  // trace control and running sums
  always_ff @(posedge clk) begin
    if (rst) begin
      active_n   <= N_W'(1);
      seen       <= '0;
      ring_pos   <= '0;
      lead_sum   <= '0;
      lead_sq    <= '0;
      trail_sum  <= '0;
      trail_sq   <= '0;
      win_sel    <= 1'b0;
      short_flag <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_acc) begin
            active_n <= n_cur;
            if (seen < SEEN_W'(SEEN_CAP)) seen <= seen + 1'b1;
            if ((RING_AW + 1)'(ring_pos) + 1'b1 >= (RING_AW + 1)'(WINDOW_MAX)) begin
              ring_pos <= '0;
            end else begin
              ring_pos <= ring_pos + 1'b1;
            end
          end
        end
        ST_OLDSQ: begin
          // prod holds s*s here
          if (lead_in) begin
            lead_sum <= lead_sum + SUM_W'(s_reg);
            lead_sq  <= lead_sq + prod[SQ_W-1:0];
          end
          trail_sum <= trail_sum + SUM_W'(s_reg);
          trail_sq  <= trail_sq + prod[SQ_W-1:0];
        end
        ST_UPD: begin
          // prod holds old*old here
          if (drop_old) begin
            trail_sum <= trail_sum - SUM_W'(old_s);
            trail_sq  <= trail_sq - prod[SQ_W-1:0];
          end
          win_sel    <= 1'b0;
          short_flag <= (seen < SEEN_W'(active_n));
        end
        ST_RMS_WAIT: begin
          if (div_done) win_sel <= 1'b1;
        end
        ST_OUT: begin
          if (out_free) begin
            seen      <= '0;
            ring_pos  <= '0;
            lead_sum  <= '0;
            lead_sq   <= '0;
            trail_sum <= '0;
            trail_sq  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // result registers of the window in progress
  always_ff @(posedge clk) begin
    if (state == ST_MULB) a_reg <= prod;
    if (state == ST_MEAN_WAIT && div_done) begin
      if (win_sel) mean_t <= div_q[Q4_W-1:0];
      else         mean_f <= div_q[Q4_W-1:0];
    end
    if (state == ST_RMS_WAIT && div_done) begin
      if (win_sel) rms_t <= div_q[Q4_W-1:0];
      else         rms_f <= div_q[Q4_W-1:0];
    end
  end

  assign mean_diff = DIFF_W'(mean_f) - DIFF_W'(mean_t);

  // output register, holds a beat while the next trace streams in
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      m_axis_tuser <= short_flag;
      if (short_flag) begin
        m_axis_tdata <= '0;
      end else begin
        m_axis_tdata <= OUT_W'({mean_diff, rms_t, mean_t, rms_f, mean_f});
      end
    end
  end

  twebs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (active_n),
    .done     (div_done),
    .quotient (div_q)
  );

  twebs_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (RAD_W'({var_v, 8'h00})),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import twebs_pkg::*;

  // timing of the run
  localparam int HALF_PERIOD  = 2;
  localparam int DRAIN_CYCLES = 250;   // settle time after the last result beat
  localparam int HOLD_CYCLES  = 3000;  // long receiver hold-off
  localparam int RANDOM_ITEMS = 850;
  localparam int MAX_SHOWN    = 40;    // mismatch lines printed before going quiet

  // one result beat, split into its fields
  typedef struct {
    bit [Q4_W-1:0]   mean_first;
    bit [Q4_W-1:0]   rms_first;
    bit [Q4_W-1:0]   mean_trail;
    bit [Q4_W-1:0]   rms_trail;
    bit [DIFF_W-1:0] mean_diff;
    bit              short_trace;
  } edge_stats_t;

  // predicts the edge-window statistics of each trace and checks the result beats
  class baseline_scoreboard;
    bit [CFG_W-1:0]       window_reg;
    int unsigned          active_n;
    longint unsigned      lead_sx, lead_sxx, trail_sx, trail_sxx;
    bit [SAMPLE_BITS-1:0] ring [WINDOW_MAX];
    int unsigned          seen, ring_pos;
    edge_stats_t          stats_due [$];
    int unsigned          mismatches, traces, short_traces, samples, checked;

    function new();
      window_reg = CFG_W'(WINDOW_RESET);
      active_n   = 1;
      clear_sums();
    endfunction

    function void clear_sums();
      lead_sx   = 0;
      lead_sxx  = 0;
      trail_sx  = 0;
      trail_sxx = 0;
      seen      = 0;
      ring_pos  = 0;
    endfunction

    // window size the next trace will latch
    function int unsigned clamped_window();
      if (window_reg == 0) return 1;
      if (window_reg > WINDOW_MAX) return WINDOW_MAX;
      return window_reg;
    endfunction

    static function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned root, probe;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > x) probe >>= 2;
      while (probe != 0) begin
        if (x >= root + probe) begin
          x    = x - (root + probe);
          root = (root >> 1) + probe;
        end else begin
          root = root >> 1;
        end
        probe >>= 2;
      end
      return root;
    endfunction

    static function bit [Q4_W-1:0] mean_q4(longint unsigned sx, int unsigned n);
      return Q4_W'((sx << 4) / n);
    endfunction

    static function bit [Q4_W-1:0] rms_q4(longint unsigned sx, longint unsigned sxx,
                                          int unsigned n);
      longint unsigned nsxx, sx2, spread;
      nsxx   = n * sxx;
      sx2    = sx * sx;
      spread = (nsxx > sx2) ? nsxx - sx2 : 0;
      return Q4_W'(int_sqrt(spread << 8) / n);
    endfunction

    // accepted sample beat: update the running sums, queue a result on the last one
    function void take_sample(bit [SAMPLE_BITS-1:0] s, bit last);
      longint unsigned x, old;
      int unsigned     idx;
      edge_stats_t     r;
      x = s;
      samples++;
      if (seen == 0) active_n = clamped_window();
      if (seen < active_n) begin
        lead_sx  += x;
        lead_sxx += x * x;
      end
      trail_sx  += x;
      trail_sxx += x * x;
      // drop the sample that just slid out of the trailing window
      if (seen >= active_n) begin
        idx        = (ring_pos + WINDOW_MAX - active_n) % WINDOW_MAX;
        old        = ring[idx];
        trail_sx  -= old;
        trail_sxx -= old * old;
      end
      ring[ring_pos] = s;
      ring_pos       = (ring_pos + 1) % WINDOW_MAX;
      if (seen < SEEN_CAP) seen++;
      if (!last) return;
      traces++;
      r = '{default: 0};
      if (seen < active_n) begin
        r.short_trace = 1'b1;
        short_traces++;
      end else begin
        r.mean_first = mean_q4(lead_sx, active_n);
        r.rms_first  = rms_q4(lead_sx, lead_sxx, active_n);
        r.mean_trail = mean_q4(trail_sx, active_n);
        r.rms_trail  = rms_q4(trail_sx, trail_sxx, active_n);
        r.mean_diff  = {1'b0, r.mean_first} - {1'b0, r.mean_trail};
      end
      stats_due.insert(stats_due.size(), r);
      clear_sums();
    endfunction

    task report_mismatch(string msg);
      if (mismatches < MAX_SHOWN) $display("ERROR at %0t ns: %s", $time, msg);
      mismatches++;
    endtask

    task compare_field(string name, longint unsigned got, longint unsigned want);
      if (got != want)
        report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                  checked, name, got, want));
    endtask

    // accepted result beat against the oldest pending trace
    task check_stats(bit [OUT_W-1:0] d, bit user);
      edge_stats_t want;
      if (stats_due.size() == 0) begin
        report_mismatch("result beat while no trace end is pending");
        return;
      end
      want = stats_due.pop_front();
      compare_field("mean_first", d[15:0], want.mean_first);
      compare_field("rms_first", d[31:16], want.rms_first);
      compare_field("mean_trailing", d[47:32], want.mean_trail);
      compare_field("rms_trailing", d[63:48], want.rms_trail);
      compare_field("mean_difference", d[80:64], want.mean_diff);
      compare_field("short_trace", user, want.short_trace);
      checked++;
    endtask
  endclass

  logic             clk;
  logic             rst           = 1'b1;
  logic             cfg_we        = 1'b0;
  logic [CFG_W-1:0] cfg_wdata     = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata  = '0;  // [11:0] sample
  logic             s_axis_tlast  = 1'b0;  // last_sample
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;  // [15:0] mean_first, [31:16] rms_first,
                                   // [47:32] mean_trailing, [63:48] rms_trailing,
                                   // [80:64] mean_difference
  logic             m_axis_tuser;  // short_trace

  // idling odds per hundred, set per phase
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_off       = 1'b0;
  bit          pressure_go    = 1'b0;
  int unsigned random_samples = 0;

  baseline_scoreboard stats_board = new();

  trace_edge_window_baseline_stats dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  // result side: check each accepted beat, then pick the next tready
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      stats_board.check_stats(m_axis_tdata, m_axis_tuser);
    if (hold_off) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // long hold-off on the result side, counted here, so the block backs up
  // into its sample input while the sender keeps offering beats
  initial begin
    wait (pressure_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // register write, only while the block is idle
  task automatic write_window(bit [CFG_W-1:0] w);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we    <= 1'b0;
    stats_board.window_reg = w;
  endtask

  // one sample beat, with random idle cycles ahead of it
  task automatic send_sample(bit [SAMPLE_BITS-1:0] s, bit last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'(s);
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    stats_board.take_sample(s, last);
  endtask

  // wait until every trace end has produced its result, then let the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (stats_board.stats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one trace of random length around the window and one of several sample shapes
  task automatic run_trace(int unsigned forced_len);
    int unsigned n, len, shape, base_a, base_b, v, i;
    n = stats_board.clamped_window();
    if (forced_len != 0) begin
      len = forced_len;
    end else begin
      case ($urandom_range(0, 9))
        0, 1: len = (n > 1) ? $urandom_range(1, n - 1) : 1;  // short trace
        2: len = n;                                           // exactly one window
        8: len = 1;
        9: len = $urandom_range(n, 3 * n);
        default: len = $urandom_range(n + 1, 2 * n + 8);      // longer than one window, windows overlap when under 2n
      endcase
    end
    shape  = $urandom_range(0, 4);
    base_a = $urandom_range(0, 4095);
    base_b = $urandom_range(0, 4095);
    for (i = 0; i < len; i++) begin
      case (shape)
        0: v = $urandom_range(0, 4095);
        1: begin  // quiet baseline with a little noise
          v = base_a + $urandom_range(0, 16);
          v = (v < 8) ? 0 : v - 8;
          if (v > 4095) v = 4095;
        end
        2: v = $urandom_range(0, 1) ? 4095 : 0;
        3: v = base_a;
        default: v = (i < len / 2) ? base_a : base_b;  // baseline step
      endcase
      send_sample(v[SAMPLE_BITS-1:0], i == len - 1);
      if (forced_len == 0) random_samples++;
    end
  endtask

  task automatic run_phase(bit [CFG_W-1:0] w, int unsigned send_pct,
                           int unsigned recv_pct, int unsigned quota);
    int unsigned start;
    write_window(w);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    start          = random_samples;
    while (random_samples - start < quota) run_trace(0);
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset window of 100: a 3-sample trace is short
    send_sample(12'd0, 1'b0);
    send_sample(12'd4095, 1'b0);
    send_sample(12'd2048, 1'b1);
    drain();

    // window of 2: full-scale constant, overlapping swing, single short sample
    write_window(8'd2);
    send_sample(12'd4095, 1'b0);
    send_sample(12'd4095, 1'b1);
    send_sample(12'd0, 1'b0);
    send_sample(12'd4095, 1'b0);
    send_sample(12'd0, 1'b1);
    send_sample(12'd7, 1'b1);
    drain();

    // window of 0 acts as 1
    write_window(8'd0);
    send_sample(12'd4095, 1'b1);
    send_sample(12'd0, 1'b0);
    send_sample(12'd4095, 1'b1);
    drain();

    // window above the maximum acts as 128
    write_window(8'd255);
    send_sample(12'd1, 1'b1);
    drain();

    // window of 1 with alternating bit patterns
    write_window(8'd1);
    send_sample(12'd0, 1'b1);
    send_sample(12'd2730, 1'b1);
    send_sample(12'd1365, 1'b1);
    drain();

    // random traces under the idling mixes
    run_phase(8'd5, 0, 0, 130);
    run_phase(8'd1, 72, 0, 110);
    run_phase(8'd9, 0, 72, 130);
    run_phase(8'd17, 17, 17, 130);
    run_phase(8'd128, 17, 17, 110);

    // result side held off while traces keep coming
    pressure_go = 1'b1;
    run_phase(8'd3, 0, 0, 90);

    // everything stalling, until enough samples have gone through
    write_window(CFG_W'($urandom_range(1, 40)));
    send_idle_pct  = 72;
    recv_stall_pct = 72;
    while (random_samples < RANDOM_ITEMS) run_trace(0);
    drain();

    $display("covered %0d traces (%0d short) from %0d sample beats", stats_board.traces,
             stats_board.short_traces, stats_board.samples);
    $display("window settings 0, 1 to 128 and 255, idling mixes, long result hold-off");
    if (stats_board.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // overall limit, far above the slowest correct run
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
